// File: rtl/core/column_shift_resampler_macros.svh
// Assertion helpers used by the checker file.
`ifndef COLUMN_SHIFT_RESAMPLER_MACROS_SVH
`define COLUMN_SHIFT_RESAMPLER_MACROS_SVH

// Property checked on every rising clk_i edge, masked while rstn is low.
`define CSR_ASSERT(lbl, rstn, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clk_i edge, reset included.
`define CSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/csr_pkg.sv
package csr_pkg;

  localparam int unsigned ROW_W      = 12;
  localparam int unsigned IO_W       = 32;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned ROWS_RESET = 4096;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned FIFO_DEPTH = 2;

  // What the back end does with one queued item.
  typedef enum logic [KIND_W-1:0] {
    KIND_NOP,
    KIND_LOAD,
    KIND_ZERO,
    KIND_EDGE,
    KIND_BLEND
  } kind_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: rtl/core/csr_fifo.sv
module csr_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       push_data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       pop_data_o,
  output csr_pkg::fifo_stat_t    stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/core/csr_front.sv
module csr_front #(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned AW          = 12,
  parameter int unsigned ENTRY_W     = 91
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                in_mode_i,
  input  logic [csr_pkg::ROW_W-1:0]           in_row_i,
  input  logic signed [csr_pkg::IO_W-1:0]     in_sample_i,
  input  logic signed [csr_pkg::IO_W-1:0]     in_offset_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csr_pkg::CFG_W-1:0]           cfg_rows_in_use_i,
  output logic                                push_o,
  output logic [ENTRY_W-1:0]                  push_entry_o,
  input  csr_pkg::fifo_stat_t                 fifo_stat_i
);

  localparam int unsigned SHIFTED_W = csr_pkg::ROW_W + FRAC_BITS;
  localparam int unsigned POS_W =
    ((SHIFTED_W > csr_pkg::IO_W) ? SHIFTED_W : csr_pkg::IO_W) + 1;
  localparam int unsigned JM_W  = POS_W - FRAC_BITS;
  localparam int unsigned DIM_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W = ((JM_W > DIM_W) ? JM_W : DIM_W) + 1;
  localparam int unsigned DIM_RESET =
    (csr_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS : csr_pkg::ROWS_RESET;
  localparam logic signed [CMP_W-1:0] ONE_C = CMP_W'(1);

  typedef struct packed {
    csr_pkg::kind_e          kind;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic [FRAC_BITS-1:0]    frac;
    logic [SAMPLE_BITS-1:0]  sample;
  } entry_t;

  logic [DIM_W-1:0]        dim_q, dim_d;
  logic signed [POS_W-1:0] row_pos, off_ext, pos;
  logic signed [JM_W-1:0]  jm;
  logic signed [CMP_W-1:0] jm_c, dim_c;
  entry_t                  ent;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fifo_stat_i.full;

  // Saturate the row count once at write time.
  always_comb begin
    if (cfg_rows_in_use_i < csr_pkg::CFG_W'(2)) begin
      dim_d = DIM_W'(2);
    end else if (32'(cfg_rows_in_use_i) > MAX_ROWS) begin
      dim_d = DIM_W'(MAX_ROWS);
    end else begin
      dim_d = DIM_W'(cfg_rows_in_use_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_W'(DIM_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      dim_q <= dim_d;
    end
  end

  assign row_pos = POS_W'({in_row_i, {FRAC_BITS{1'b0}}});
  assign off_ext = POS_W'(in_offset_i);
  assign pos     = row_pos + off_ext;
  // Arithmetic shift of the position gives the floor row.
  assign jm      = pos[POS_W-1:FRAC_BITS];
  assign jm_c    = CMP_W'(jm);
  assign dim_c   = CMP_W'(dim_q);

  always_comb begin
    ent.kind   = csr_pkg::KIND_NOP;
    ent.addr_a = '0;
    ent.addr_b = '0;
    ent.frac   = pos[FRAC_BITS-1:0];
    ent.sample = SAMPLE_BITS'(in_sample_i);
    if (!in_mode_i) begin
      ent.addr_a = AW'(in_row_i);
      if (32'(in_row_i) < MAX_ROWS) begin
        ent.kind = csr_pkg::KIND_LOAD;
      end
    end else if (jm_c < 0) begin
      ent.kind = (jm_c == -ONE_C) ? csr_pkg::KIND_EDGE : csr_pkg::KIND_ZERO;
    end else if (jm_c >= dim_c - ONE_C) begin
      ent.addr_a = AW'(dim_q - DIM_W'(1));
      ent.kind   = (jm_c == dim_c - ONE_C) ? csr_pkg::KIND_EDGE : csr_pkg::KIND_ZERO;
    end else begin
      ent.kind   = csr_pkg::KIND_BLEND;
      ent.addr_a = AW'(jm_c);
      ent.addr_b = AW'(jm_c + ONE_C);
    end
  end

  // Drop loads beyond the store; they never reach the back end.
  assign push_o       = in_valid_i && !in_stall_o && (ent.kind != csr_pkg::KIND_NOP);
  assign push_entry_o = ENTRY_W'(ent);

endmodule

// File: rtl/core/csr_back.sv
module csr_back #(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned AW          = 12,
  parameter int unsigned ENTRY_W     = 91
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  csr_pkg::fifo_stat_t             fifo_stat_i,
  output logic                            pop_o,
  input  logic [ENTRY_W-1:0]              pop_entry_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [csr_pkg::IO_W-1:0] out_value_o
);

  localparam int unsigned PRD_W = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned SUM_W = PRD_W + 1;
  localparam logic [SUM_W-1:0]    HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0]  ONE  = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    csr_pkg::kind_e          kind;
    logic [AW-1:0]           addr_a;
    logic [AW-1:0]           addr_b;
    logic [FRAC_BITS-1:0]    frac;
    logic [SAMPLE_BITS-1:0]  sample;
  } entry_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'b001,
    BK_READ = 3'b010,
    BK_SUM  = 3'b100
  } back_state_e;

  logic [SAMPLE_BITS-1:0]        store_mem [MAX_ROWS];
  entry_t                        ent;
  back_state_e                   state_q, state_d;
  logic                          we, re;
  logic                          is_edge_q;
  logic [FRAC_BITS-1:0]          frac_q;
  logic signed [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;
  logic [PRD_W-1:0]              pa_q, pb_q, pa_d, pb_d;
  logic [FRAC_BITS:0]            wa;
  logic [SUM_W-1:0]              sum;
  logic                          prd_en;
  logic                          out_valid_q, out_valid_d, out_free, out_set;
  logic signed [csr_pkg::IO_W-1:0] out_value_q, out_data;

  assign ent      = entry_t'(pop_entry_i);
  assign out_free = !out_valid_q || !out_stall_i;

  // Both samples are positive here, so the magnitudes drop the sign bit.
  assign wa   = ONE - {1'b0, frac_q};
  assign pa_d = PRD_W'(rd_a_q[SAMPLE_BITS-2:0]) * PRD_W'(wa);
  assign pb_d = PRD_W'(rd_b_q[SAMPLE_BITS-2:0]) * PRD_W'(frac_q);
  assign sum  = SUM_W'(pa_q) + SUM_W'(pb_q) + HALF;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    re       = 1'b0;
    prd_en   = 1'b0;
    out_set  = 1'b0;
    out_data = '0;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_stat_i.empty) begin
          case (ent.kind)
            csr_pkg::KIND_LOAD: begin
              pop_o = 1'b1;
              we    = 1'b1;
            end
            csr_pkg::KIND_ZERO: begin
              if (out_free) begin
                pop_o   = 1'b1;
                out_set = 1'b1;
              end
            end
            csr_pkg::KIND_EDGE, csr_pkg::KIND_BLEND: begin
              pop_o   = 1'b1;
              re      = 1'b1;
              state_d = BK_READ;
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_READ: begin
        if (is_edge_q || rd_b_q <= 0) begin
          if (out_free) begin
            out_set  = 1'b1;
            out_data = csr_pkg::IO_W'(rd_a_q);
            state_d  = BK_IDLE;
          end
        end else if (rd_a_q <= 0) begin
          if (out_free) begin
            out_set  = 1'b1;
            out_data = csr_pkg::IO_W'(rd_b_q);
            state_d  = BK_IDLE;
          end
        end else begin
          prd_en  = 1'b1;
          state_d = BK_SUM;
        end
      end
      BK_SUM: begin
        if (out_free) begin
          out_set  = 1'b1;
          out_data = csr_pkg::IO_W'($signed(sum[FRAC_BITS +: SAMPLE_BITS]));
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_set || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      is_edge_q <= (ent.kind == csr_pkg::KIND_EDGE);
      frac_q    <= ent.frac;
    end
    if (prd_en) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (out_set) begin
      out_value_q <= out_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[ent.addr_a] <= ent.sample;
    end
    if (re) begin
      rd_a_q <= store_mem[ent.addr_a];
      rd_b_q <= store_mem[ent.addr_b];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;

endmodule

// File: rtl/core/column_shift_resampler.sv
// Column shift resampler.
// Input channel (in_valid_i / in_stall_o): an item is taken on a clock edge
// with valid high and stall low. Mode 0 stores in_sample_i at in_row_i;
// mode 1 resamples in_row_i shifted by in_offset_i (FRAC_BITS fraction bits)
// and gives one value on the output channel (out_valid_o / out_stall_i).
// Configuration: cfg_rows_in_use_i is written when cfg_valid_i is high;
// cfg_ready_o is always high. Write it only while the block is idle.
// Loads are written to the store as they are popped and never wait on the
// output. A resample holds the back end until its result is set. An
// out-of-column result passes the queue and output register; an edge or
// single-neighbor one also the store read; a blend also the multiply stage.
// A two-entry queue parts the classifying front from the back end.
// Reset clears the queue and the output valid and sets the row count to
// 4096 (saturated to MAX_ROWS); store contents are undefined until loaded.
// While out_stall_i is high the result holds, the back end waits once it has
// a further result to give, the queue fills, and in_stall_o rises when full.
module column_shift_resampler #(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned SAMPLE_BITS = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_mode_i,
  input  logic [csr_pkg::ROW_W-1:0]       in_row_i,
  input  logic signed [csr_pkg::IO_W-1:0] in_sample_i,
  input  logic signed [csr_pkg::IO_W-1:0] in_offset_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [csr_pkg::IO_W-1:0] out_value_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [csr_pkg::CFG_W-1:0]       cfg_rows_in_use_i
);

  localparam int unsigned AW      = $clog2(MAX_ROWS);
  localparam int unsigned ENTRY_W = csr_pkg::KIND_W + 2 * AW + FRAC_BITS + SAMPLE_BITS;

  logic                push;
  logic                pop;
  logic [ENTRY_W-1:0]  push_entry;
  logic [ENTRY_W-1:0]  pop_entry;
  csr_pkg::fifo_stat_t fifo_stat;

  csr_front #(
    .MAX_ROWS   (MAX_ROWS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_mode_i        (in_mode_i),
    .in_row_i         (in_row_i),
    .in_sample_i      (in_sample_i),
    .in_offset_i      (in_offset_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_rows_in_use_i(cfg_rows_in_use_i),
    .push_o           (push),
    .push_entry_o     (push_entry),
    .fifo_stat_i      (fifo_stat)
  );

  csr_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(csr_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_entry),
    .pop_i      (pop),
    .pop_data_o (pop_entry),
    .stat_o     (fifo_stat)
  );

  csr_back #(
    .MAX_ROWS   (MAX_ROWS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .AW         (AW),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fifo_stat_i(fifo_stat),
    .pop_o      (pop),
    .pop_entry_i(pop_entry),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_value_o(out_value_o)
  );

endmodule

// File: rtl/core/csr_checker.sv
`include "column_shift_resampler_macros.svh"

module csr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            in_mode_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic signed [csr_pkg::IO_W-1:0] out_value_o
);

  logic [3:0] pend_q;
  logic       rs_take, out_take, out_hold;

  assign rs_take  = in_valid_i && !in_stall_o && in_mode_i;
  assign out_take = out_valid_o && !out_stall_i;
  assign out_hold = out_valid_o && out_stall_i;

  // Count resample items taken in whose result has not yet left.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(rs_take) - 4'(out_take);
    end
  end

  `CSR_ASSERT_ALWAYS(a_reset_no_out, !rst_ni |-> !out_valid_o, "output valid during reset")
  `CSR_ASSERT(a_out_hold, rst_ni, out_hold |=> out_valid_o, "stalled output dropped")
  `CSR_ASSERT(a_out_stable, rst_ni, out_hold |=> $stable(out_value_o), "stalled output changed")
  `CSR_ASSERT(a_no_invented, rst_ni, out_valid_o |-> pend_q != 4'd0, "unexpected output")

endmodule

bind column_shift_resampler csr_checker u_csr_checker (.*);
